// ===== rtl/core/mkprd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkprd_pkg
// Shared constants and types of the multi-key press/release debouncer.
// ----------------------------------------------------------------------------
package mkprd_pkg;

    localparam int NUM_CHANNELS = 8;   // active lanes, 1..8
    localparam int KEY_COUNT    = 8;   // width of the key and event masks

    localparam int ELAPSED_W = 16;
    localparam int FTIME_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = ELAPSED_W + 1;

    localparam logic [FTIME_W-1:0] FTIME_RESET = 8'd20;

    // Channel phase codes
    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_PRESS_FILT = 2'd1;
    localparam logic [1:0] PH_WAIT_REL   = 2'd2;
    localparam logic [1:0] PH_REL_FILT   = 2'd3;

    // Event masks of one tick, press in the low byte
    typedef struct packed {
        logic [KEY_COUNT-1:0] release_mask;
        logic [KEY_COUNT-1:0] press_mask;
    } event_mask_t;

    // What one lane found on the current tick
    typedef struct packed {
        logic press;
        logic release_evt;
    } lane_evt_t;

endpackage : mkprd_pkg
`default_nettype wire

// ===== rtl/core/mkprd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkprd_lane
// One debounce channel: four-phase machine with a filter time counter.
// ----------------------------------------------------------------------------
module mkprd_lane
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               tick,        // input transfer
    input  wire logic                               level,
    input  wire logic [mkprd_pkg::ELAPSED_W-1:0]    elapsed_ms,
    input  wire logic [mkprd_pkg::FTIME_W-1:0]      filter_time,
    output mkprd_pkg::lane_evt_t                    evt
);

    logic [1:0]                      phase_reg, phase_next;
    // The count stays below the filter time while held, so 8 bits suffice
    logic [mkprd_pkg::FTIME_W-1:0]   count_reg, count_next;
    logic [mkprd_pkg::SUM_W-1:0]     sum;
    logic                            reached;

    assign sum     = {{(mkprd_pkg::SUM_W-mkprd_pkg::FTIME_W){1'b0}}, count_reg}
                   + {1'b0, elapsed_ms};
    assign reached = sum >= {{(mkprd_pkg::SUM_W-mkprd_pkg::FTIME_W){1'b0}}, filter_time};

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        evt.press       = 1'b0;
        evt.release_evt = 1'b0;
        unique case (phase_reg)
            mkprd_pkg::PH_IDLE:
            begin
                if (level)
                begin
                    count_next = '0;
                    phase_next = mkprd_pkg::PH_PRESS_FILT;
                end
            end
            mkprd_pkg::PH_PRESS_FILT:
            begin
                count_next = sum[mkprd_pkg::FTIME_W-1:0];
                if (reached)
                begin
                    evt.press  = level;
                    phase_next = level ? mkprd_pkg::PH_WAIT_REL : mkprd_pkg::PH_IDLE;
                end
            end
            mkprd_pkg::PH_WAIT_REL:
            begin
                if (!level)
                begin
                    count_next = '0;
                    phase_next = mkprd_pkg::PH_REL_FILT;
                end
            end
            default:
            begin
                count_next = sum[mkprd_pkg::FTIME_W-1:0];
                if (reached)
                begin
                    evt.release_evt = !level;
                    phase_next = level ? mkprd_pkg::PH_WAIT_REL : mkprd_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mkprd_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule : mkprd_lane
`default_nettype wire

// ===== rtl/core/mkprd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkprd_merge
// Gather the lane events into masks; output register plus skid stage.
// ----------------------------------------------------------------------------
module mkprd_merge
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_fire,
    input  wire logic [mkprd_pkg::KEY_COUNT-1:0]    press_vec,
    input  wire logic [mkprd_pkg::KEY_COUNT-1:0]    release_vec,
    output logic                                    in_ready,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output mkprd_pkg::event_mask_t                  out_data
);

    mkprd_pkg::event_mask_t  merged;
    mkprd_pkg::event_mask_t  out_reg, out_next;
    mkprd_pkg::event_mask_t  skid_reg, skid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic                    out_fire;

    assign merged.press_mask   = press_vec;
    assign merged.release_mask = release_vec;
    assign out_fire            = out_valid_reg && out_ready;
    assign in_ready            = !skid_valid_reg;
    assign out_valid           = out_valid_reg;
    assign out_data            = out_reg;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            // Output slot frees up: drain the skid first, then the new tick
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = merged;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            // Receiver stalls: park the tick in the skid
            skid_next       = merged;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule : mkprd_merge
`default_nettype wire

// ===== rtl/core/multi_key_press_release_debounce_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_press_release_debounce_top
// Eight-channel key debouncer with filtering on both press and release.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one time tick: the milliseconds
//   passed since the previous tick and one raw level bit per key. Every tick
//   yields exactly one transfer on m_axis with the press and release event
//   masks found on that tick.
//   The lanes update on the accepting edge, which also loads the masks into
//   the output register (or the skid if full). One tick per cycle is kept
//   up with m_axis_tready high, set by the single add and compare per lane.
//   When the receiver stalls, one further tick is held in a skid stage and
//   s_axis_tready drops only once both output register and skid are full.
//   Reset puts every channel in idle with a cleared count, empties the
//   output stages, and loads 20 ms into every filter time register.
//   Filter times are written through cfg_we/cfg_index/cfg_wdata, one per
//   cycle, and take effect at the next compare of that channel.
// ----------------------------------------------------------------------------
module multi_key_press_release_debounce_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [mkprd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mkprd_pkg::FTIME_W-1:0]       cfg_wdata,
    // Tick input
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [23:0]                         s_axis_tdata,  // elapsed_ms[15:0], key_levels[23:16]
    // Event output
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [15:0]                              m_axis_tdata   // press_events[7:0], release_events[15:8]
);

    logic [mkprd_pkg::FTIME_W-1:0]    filter_time_reg [mkprd_pkg::KEY_COUNT];
    logic                             in_fire;
    logic [mkprd_pkg::ELAPSED_W-1:0]  elapsed_ms;
    logic [mkprd_pkg::KEY_COUNT-1:0]  key_levels;
    logic [mkprd_pkg::KEY_COUNT-1:0]  press_vec;
    logic [mkprd_pkg::KEY_COUNT-1:0]  release_vec;
    mkprd_pkg::event_mask_t           out_data;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign elapsed_ms = s_axis_tdata[mkprd_pkg::ELAPSED_W-1:0];
    assign key_levels = s_axis_tdata[mkprd_pkg::ELAPSED_W +: mkprd_pkg::KEY_COUNT];

    // Filter time registers: plain write, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mkprd_pkg::KEY_COUNT; i++)
            begin
                filter_time_reg[i] <= mkprd_pkg::FTIME_RESET;
            end
        end
        else if (cfg_we)
        begin
            filter_time_reg[cfg_index] <= cfg_wdata;
        end
    end

    // One lane per active channel; unused channels report no events
    for (genvar g = 0; g < mkprd_pkg::KEY_COUNT; g++)
    begin : g_lane
        if (g < mkprd_pkg::NUM_CHANNELS)
        begin : g_on
            mkprd_pkg::lane_evt_t evt;

            mkprd_lane u_lane
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .tick        (in_fire),
                .level       (key_levels[g]),
                .elapsed_ms  (elapsed_ms),
                .filter_time (filter_time_reg[g]),
                .evt         (evt)
            );

            assign press_vec[g]   = evt.press;
            assign release_vec[g] = evt.release_evt;
        end
        else
        begin : g_off
            assign press_vec[g]   = 1'b0;
            assign release_vec[g] = 1'b0;
        end
    end

    // Merge the lane events and hold them for the receiver
    mkprd_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .press_vec   (press_vec),
        .release_vec (release_vec),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule : multi_key_press_release_debounce_top
`default_nettype wire
